FILE: sv/wto_pkg.sv
// shared types and constants for the wavetable oscillator
// no dependencies
package wto_pkg;

  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned TIDX_W     = 10;
  localparam int unsigned ADDR_W_MAX = 16;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam logic [PHASE_W-1:0] PHASE_INC_RESET = 32'd39370534;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_TICK_EXT  = 2'd1,
    OP_WRITE     = 2'd2,
    OP_SET_PHASE = 2'd3
  } wto_op_e;

  // one queued table access: either a lookup (addr = x0 index, data = frac)
  // or a table write (addr = entry, data = sample)
  typedef struct packed {
    logic                  is_wr;
    logic [ADDR_W_MAX-1:0] addr;
    logic [SAMPLE_W-1:0]   data;
  } wto_entry_t;

endpackage

FILE: sv/wto_ram.sv
// generic single write port ram with registered read
// no dependencies
module wto_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/wto_front.sv
// front end: accepts words, keeps the phase accumulator and increment,
// turns ticks and table writes into queue entries; uses wto_pkg
module wto_front #(
  parameter int unsigned TABLE_SIZE = 1024,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wto_pkg::PHASE_W-1:0]    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     op_i,
  input  logic [wto_pkg::PHASE_W-1:0]    phase_in_i,
  input  logic [wto_pkg::TIDX_W-1:0]     table_index_i,
  input  logic signed [wto_pkg::SAMPLE_W-1:0] table_value_i,
  input  logic                           full_i,
  output logic                           push_o,
  output wto_pkg::wto_entry_t            entry_o
);
  import wto_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_SIZE);

  logic [PHASE_W-1:0]    phase_inc_q;
  logic [PHASE_W-1:0]    phase_q, phase_d;
  logic                  accept;
  logic [PHASE_W-1:0]    lk_phase;
  logic [PHASE_W-1:0]    lk_rest;
  logic [ADDR_W_MAX-1:0] wr_addr;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign lk_phase = (op_i == OP_TICK_EXT) ? phase_in_i : phase_q;
  assign lk_rest  = lk_phase << AW;
  assign wr_addr  = ADDR_W_MAX'(table_index_i) & ADDR_W_MAX'(TABLE_SIZE - 1);

  always_comb begin
    phase_d = phase_q;
    push_o  = 1'b0;
    entry_o = '0;
    case (op_i)
      OP_TICK, OP_TICK_EXT: begin
        push_o        = accept;
        entry_o.is_wr = 1'b0;
        entry_o.addr  = ADDR_W_MAX'(lk_phase[PHASE_W-1 -: AW]);
        entry_o.data  = SAMPLE_W'(lk_rest[PHASE_W-1 -: FRAC_BITS]);
        if (op_i == OP_TICK) begin
          phase_d = phase_q + phase_inc_q;
        end
      end
      OP_WRITE: begin
        push_o        = accept;
        entry_o.is_wr = 1'b1;
        entry_o.addr  = wr_addr;
        entry_o.data  = table_value_i;
      end
      OP_SET_PHASE: begin
        phase_d = phase_in_i;
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_inc_q <= PHASE_INC_RESET;
      phase_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        phase_inc_q <= cfg_wdata_i;
      end
      if (accept) begin
        phase_q <= phase_d;
      end
    end
  end

endmodule

FILE: sv/wto_fifo.sv
// short queue between front and back ends
// uses wto_pkg for the entry type and depth
module wto_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  wto_pkg::wto_entry_t entry_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                pop_i,
  output wto_pkg::wto_entry_t entry_o
);
  import wto_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  wto_entry_t       buf_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = buf_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue pop while empty");

endmodule

FILE: sv/wto_back.sv
// back end: table ram access, difference times fraction, final add
// uses wto_pkg and two wto_ram banks holding the same samples
module wto_back #(
  parameter int unsigned TABLE_SIZE = 1024,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  input  wto_pkg::wto_entry_t                 q_entry_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [wto_pkg::SAMPLE_W-1:0] sample_o
);
  import wto_pkg::*;

  localparam int unsigned AW   = $clog2(TABLE_SIZE);
  localparam int unsigned DIFF_W = SAMPLE_W + 1;
  localparam int unsigned PROD_W = FRAC_BITS + 1 + DIFF_W;

  logic                       advance;
  logic                       ram_we, ram_re;
  logic [AW-1:0]              addr0, addr1;
  logic [SAMPLE_W-1:0]        x0_raw, x1_raw;
  logic signed [SAMPLE_W-1:0] x0, x1;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic signed [PROD_W-1:0]   prod_shr;
  logic                       s1_valid_q;
  logic [FRAC_BITS-1:0]       s1_frac_q;
  logic                       s2_valid_q;
  logic signed [SAMPLE_W-1:0] s2_x0_q;
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;

  assign advance = !out_valid_q || out_ready_i;
  assign q_pop_o = advance && q_valid_i;
  assign ram_we  = q_pop_o && q_entry_i.is_wr;
  assign ram_re  = q_pop_o && !q_entry_i.is_wr;
  assign addr0   = q_entry_i.addr[AW-1:0];
  assign addr1   = addr0 + 1'b1;

  wto_ram #(.WIDTH(SAMPLE_W), .DEPTH(TABLE_SIZE)) u_bank0 (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(addr0),
    .wdata_i(q_entry_i.data),
    .re_i   (ram_re),
    .raddr_i(addr0),
    .rdata_o(x0_raw)
  );

  wto_ram #(.WIDTH(SAMPLE_W), .DEPTH(TABLE_SIZE)) u_bank1 (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(addr0),
    .wdata_i(q_entry_i.data),
    .re_i   (ram_re),
    .raddr_i(addr1),
    .rdata_o(x1_raw)
  );

  assign x0     = $signed(x0_raw);
  assign x1     = $signed(x1_raw);
  assign diff   = DIFF_W'(x1) - DIFF_W'(x0);
  assign prod_d = PROD_W'($signed({1'b0, s1_frac_q}) * diff);

  // arithmetic shift floors, result always lies between x0 and x1
  assign prod_shr = prod_q >>> FRAC_BITS;
  assign sample_d = s2_x0_q + prod_shr[SAMPLE_W-1:0];

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_frac_q <= q_entry_i.data[FRAC_BITS-1:0];
      prod_q    <= prod_d;
      s2_x0_q   <= x0;
      sample_q  <= sample_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= ram_re;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> !s1_valid_q)
    else $error("table write produced a lookup slot");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(s1_valid_q) && $stable(s2_valid_q))
    else $error("back pipeline moved during stall");

endmodule

FILE: sv/wavetable_oscillator_linear_interp_top.sv
// wavetable oscillator, linear interpolation: a tick passes the queue, ram/s1, s2
// and output registers to sample valid; one word per cycle while the queue has
// room, set by the front end phase add and one lookup per cycle in the two table
// banks. the 4-entry queue absorbs output stalls. reset zeroes the phase, loads
// the increment with 440 Hz at 48 kHz and empties the pipeline; table undefined
module wavetable_oscillator_linear_interp_top #(
  parameter int unsigned TABLE_SIZE = 1024,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wto_pkg::PHASE_W-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          op_i,
  input  logic [wto_pkg::PHASE_W-1:0]         phase_in_i,
  input  logic [wto_pkg::TIDX_W-1:0]          table_index_i,
  input  logic signed [wto_pkg::SAMPLE_W-1:0] table_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [wto_pkg::SAMPLE_W-1:0] sample_o
);
  import wto_pkg::*;

  logic       push;
  wto_entry_t push_entry;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  wto_entry_t q_entry;

  wto_front #(.TABLE_SIZE(TABLE_SIZE), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .phase_in_i   (phase_in_i),
    .table_index_i(table_index_i),
    .table_value_i(table_value_i),
    .full_i       (q_full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  wto_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .entry_o(q_entry)
  );

  wto_back #(.TABLE_SIZE(TABLE_SIZE), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_entry_i  (q_entry),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sample_o   (sample_o)
  );

endmodule

FILE: sim/tb.sv
// testbench for wavetable_oscillator_linear_interp_top: directed table rows, a full
// table load, then random words under several increment settings, checked by a predictor
// depends on wto_pkg and the oscillator rtl only
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wto_pkg::*;

  localparam int unsigned TBL_N = 1024;
  localparam int unsigned IDX_B = $clog2(TBL_N);
  localparam int unsigned FRAC_B = 16;
  localparam int unsigned CLK_HALF = 2;
  localparam int unsigned DIR_ROWS = 19;
  localparam int unsigned NUM_PHASES = 7;
  localparam int unsigned PHASE_ITEMS = 136;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    wto_op_e                    op;
    logic [PHASE_W-1:0]         phase;
    logic [TIDX_W-1:0]          tidx;
    logic signed [SAMPLE_W-1:0] value;
    logic                       typed;
    logic signed [SAMPLE_W-1:0] want;
  } stim_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [PHASE_W-1:0]         cfg_wdata_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic [1:0]                 op_i = OP_TICK;
  logic [PHASE_W-1:0]         phase_in_i = '0;
  logic [TIDX_W-1:0]          table_index_i = '0;
  logic signed [SAMPLE_W-1:0] table_value_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_o;

  // predictor state
  logic [PHASE_W-1:0]         osc_phase = '0;
  logic [PHASE_W-1:0]         osc_incr = PHASE_INC_RESET;
  logic signed [SAMPLE_W-1:0] wave_mem [TBL_N];
  logic signed [SAMPLE_W-1:0] pending_samples [$];
  logic signed [SAMPLE_W-1:0] got_want;

  int unsigned fail_count = 0;
  int unsigned n_tick = 0, n_ext = 0, n_write = 0, n_set = 0, n_checked = 0, n_cfg = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int unsigned rx_hold = 0;

  logic [PHASE_W-1:0] incr_plan [NUM_PHASES] = '{
    32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
    32'hFFFF_FFFF, 32'h0123_4567, PHASE_INC_RESET
  };

  stim_row_t directed_rows [DIR_ROWS] = '{
    '{OP_WRITE,     32'h0000_0000, 10'd0,    16'sh7FFF, 1'b0, 16'sh0000},
    '{OP_WRITE,     32'h0000_0000, 10'd1,    16'sh8000, 1'b0, 16'sh0000},
    '{OP_WRITE,     32'h0000_0000, 10'd2,    16'sh4000, 1'b0, 16'sh0000},
    '{OP_WRITE,     32'h0000_0000, 10'd1023, 16'shFF9C, 1'b0, 16'sh0000},
    '{OP_TICK,      32'h0000_0000, 10'd0,    16'sh0000, 1'b1, 16'sh7FFF},
    '{OP_TICK_EXT,  32'h0000_0000, 10'd0,    16'sh0000, 1'b1, 16'sh7FFF},
    '{OP_TICK_EXT,  32'h003F_FFC0, 10'd0,    16'sh0000, 1'b0, 16'sh0000},
    '{OP_TICK_EXT,  32'h0020_0000, 10'd0,    16'sh0000, 1'b0, 16'sh0000},
    '{OP_TICK_EXT,  32'h0040_0000, 10'd0,    16'sh0000, 1'b1, 16'sh8000},
    '{OP_TICK_EXT,  32'hFFC0_0000, 10'd0,    16'sh0000, 1'b1, 16'shFF9C},
    '{OP_TICK_EXT,  32'hFFFF_FFFF, 10'd0,    16'sh0000, 1'b0, 16'sh0000},
    '{OP_SET_PHASE, 32'hFFE0_0000, 10'd0,    16'sh0000, 1'b0, 16'sh0000},
    '{OP_TICK,      32'h0000_0000, 10'd0,    16'sh0000, 1'b0, 16'sh0000},
    '{OP_SET_PHASE, 32'h0000_0000, 10'd0,    16'sh0000, 1'b0, 16'sh0000},
    '{OP_TICK_EXT,  32'h0040_0000, 10'd0,    16'sh0000, 1'b1, 16'sh8000},
    '{OP_TICK,      32'h0000_0000, 10'd0,    16'sh0000, 1'b1, 16'sh7FFF},
    '{OP_WRITE,     32'h0000_0000, 10'd512,  16'sh0001, 1'b0, 16'sh0000},
    '{OP_WRITE,     32'h0000_0000, 10'd513,  16'shFFFF, 1'b0, 16'sh0000},
    '{OP_TICK_EXT,  32'h8000_0040, 10'd0,    16'sh0000, 1'b0, 16'sh0000}
  };

  wavetable_oscillator_linear_interp_top #(
    .TABLE_SIZE(TBL_N),
    .FRAC_BITS (FRAC_B)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .phase_in_i   (phase_in_i),
    .table_index_i(table_index_i),
    .table_value_i(table_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_o     (sample_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  initial begin
    #4ms;
    $display("timeout with %0d samples outstanding", pending_samples.size());
    $display("FAILURE");
    $finish;
  end

  // x0 + floor(f * (x1 - x0) / 2^frac), last entry leans toward entry 0
  function automatic logic signed [SAMPLE_W-1:0] interp_sample(input logic [PHASE_W-1:0] phs);
    logic [IDX_B-1:0]   i0;
    logic [IDX_B-1:0]   i1;
    logic [PHASE_W-1:0] rest;
    longint             f;
    longint             x0;
    longint             x1;
    longint             d;
    i0 = phs[PHASE_W-1 -: IDX_B];
    i1 = i0 + 1'b1;
    rest = phs << IDX_B;
    f = longint'(rest[PHASE_W-1 -: FRAC_B]);
    x0 = longint'(wave_mem[i0]);
    x1 = longint'(wave_mem[i1]);
    d = (f * (x1 - x0)) >>> FRAC_B;
    return SAMPLE_W'(x0 + d);
  endfunction

  function automatic logic [PHASE_W-1:0] pick_phase();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7FFF;
    if (r == 1) return 16'sh8000;
    return SAMPLE_W'($urandom);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (tx_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_word(input wto_op_e op, input logic [PHASE_W-1:0] phs,
                           input logic [TIDX_W-1:0] tidx,
                           input logic signed [SAMPLE_W-1:0] tval,
                           input logic typed, input logic signed [SAMPLE_W-1:0] want);
    logic signed [SAMPLE_W-1:0] s;
    int unsigned                gap;
    op_i <= op;
    phase_in_i <= phs;
    table_index_i <= tidx;
    table_value_i <= tval;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    case (op)
      OP_TICK: begin
        s = interp_sample(osc_phase);
        osc_phase = osc_phase + osc_incr;
        pending_samples.push_back(typed ? want : s);
        n_tick++;
      end
      OP_TICK_EXT: begin
        s = interp_sample(phs);
        pending_samples.push_back(typed ? want : s);
        n_ext++;
      end
      OP_WRITE: begin
        wave_mem[tidx[IDX_B-1:0]] = tval;
        n_write++;
      end
      OP_SET_PHASE: begin
        osc_phase = phs;
        n_set++;
      end
      default: ;
    endcase
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // result side back-pressure
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else if (rx_steady || $urandom_range(0, 99) < 70) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        rx_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_samples.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("unexpected sample %0d at %0t", sample_o, $realtime);
        end
      end else begin
        got_want = pending_samples.pop_front();
        n_checked++;
        if (sample_o !== got_want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("sample mismatch at %0t: expected %0d, got %0d",
                     $realtime, got_want, sample_o);
          end
        end
      end
    end
  end

  initial begin
    int unsigned ph;
    int unsigned k;
    int unsigned r;
    wto_op_e     op;
    logic [PHASE_W-1:0] incr;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (k = 0; k < DIR_ROWS; k++) begin
      send_word(directed_rows[k].op, directed_rows[k].phase, directed_rows[k].tidx,
                directed_rows[k].value, directed_rows[k].typed, directed_rows[k].want);
    end

    // load every entry so any phase reads written samples
    for (k = 0; k < TBL_N; k++) begin
      send_word(OP_WRITE, pick_phase(), TIDX_W'(k), pick_sample(), 1'b0, '0);
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      incr = (ph == 5) ? PHASE_W'($urandom) : incr_plan[ph];
      cfg_wdata_i <= incr;
      cfg_we_i <= 1'b1;
      @(negedge clk_i);
      cfg_we_i <= 1'b0;
      osc_incr = incr;
      n_cfg++;
      tx_steady = (ph == 1 || ph == 4);
      rx_steady = (ph == 1 || ph == 5);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          op = OP_TICK;
        end else if (r < 70) begin
          op = OP_TICK_EXT;
        end else if (r < 85) begin
          op = OP_WRITE;
        end else begin
          op = OP_SET_PHASE;
        end
        send_word(op, pick_phase(), TIDX_W'($urandom), pick_sample(), 1'b0, '0);
      end
    end
    drain();

    if (pending_samples.size() != 0) fail_count++;
    $display("%0d internal ticks, %0d external ticks, %0d table writes, %0d phase sets",
             n_tick, n_ext, n_write, n_set);
    $display("%0d samples checked across %0d increment settings, %0d failures",
             n_checked, n_cfg, fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
